// ===== hdl/mjge_pkg.sv =====
// ----------------------------------------------------------------------------
// mjge_pkg
// Shared constants and types for the maze junction graph extractor.
// ----------------------------------------------------------------------------
package mjge_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   // grid width register
   localparam int                      GRID_WIDTH_W     = 11;
   localparam logic [GRID_WIDTH_W-1:0] GRID_WIDTH_RESET = 11'd1024;

   // coordinate and length fields of a result
   localparam int COORD_W = 10;
   typedef logic [COORD_W-1:0] coord_type;

   // command queue between front and back
   localparam int QUEUE_DEPTH    = 4;
   localparam int CMD_FLAG_COUNT = 6;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

endpackage

// ===== hdl/mjge_ram.sv =====
// ----------------------------------------------------------------------------
// mjge_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mjge_ram #(
   parameter  int WIDTH  = 1,
   parameter  int DEPTH  = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mjge_queue.sv =====
// ----------------------------------------------------------------------------
// mjge_queue
// Small register FIFO that decouples the classifier from the evaluator.
// ----------------------------------------------------------------------------
module mjge_queue #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data,
   output logic             full
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign pop_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/mjge_front.sv =====
// ----------------------------------------------------------------------------
// mjge_front
// Accepts cells and flush steps, tracks position and frame state, and turns
// every cell that it does not drop into a command for the back end.
// ----------------------------------------------------------------------------
module mjge_front
   import mjge_pkg::*;
#(
   parameter  int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter  int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int COL_W      = $clog2(MAX_WIDTH),
   localparam int HWM_W      = $clog2(MAX_WIDTH + 1),
   localparam int ROW_W      = $clog2(MAX_HEIGHT),
   localparam int RCNT_W     = $clog2(MAX_HEIGHT + 1),
   localparam int CMD_W      = CMD_FLAG_COUNT + COL_W + ROW_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [GRID_WIDTH_W-1:0] csr_write_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic                    req_open_cell,
   input  logic                    req_frame_start,
   input  logic                    queue_full,
   output logic                    cmd_push,
   output logic [CMD_W-1:0]        cmd_data
);

   typedef struct packed {
      logic             frame_start;
      logic             col_zero;
      logic             eval;
      logic             bottom;
      logic             center_ok;
      logic             right_ok;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cmd_type;

   logic [GRID_WIDTH_W-1:0] grid_width_ff;
   logic                    done_ff, done_in;
   logic                    drain_ff, drain_in;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [RCNT_W-1:0]       row_ff, row_in;
   logic [HWM_W-1:0]        hwm_ff, hwm_in;

   logic                    accept;
   logic                    eff_done, eff_drain;
   logic [COL_W-1:0]        eff_col;
   logic [RCNT_W-1:0]       eff_row;
   logic [HWM_W-1:0]        eff_hwm;
   logic                    start_drain, empty_done, pixel_skip, take, drain_now, row_end;
   logic [HWM_W-1:0]        width_use, col_next;
   cmd_type                 cmd;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // clamp the width register to 1..MAX_WIDTH
   always_comb begin
      if (grid_width_ff == '0) begin
         width_use = HWM_W'(1);
      end else if (32'(grid_width_ff) > MAX_WIDTH) begin
         width_use = HWM_W'(MAX_WIDTH);
      end else begin
         width_use = HWM_W'(grid_width_ff);
      end
   end

   always_comb begin
      eff_done  = req_frame_start ? 1'b0 : done_ff;
      eff_drain = req_frame_start ? 1'b0 : drain_ff;
      eff_col   = req_frame_start ? '0   : col_ff;
      eff_row   = req_frame_start ? '0   : row_ff;
      eff_hwm   = req_frame_start ? '0   : hwm_ff;

      start_drain = (req_operation == OP_FLUSH) && !eff_drain &&
                    !((eff_col != '0) && (eff_row < RCNT_W'(MAX_HEIGHT)));
      empty_done  = start_drain && (eff_row == '0);
      pixel_skip  = (req_operation == OP_PIXEL) &&
                    (eff_drain || (eff_row >= RCNT_W'(MAX_HEIGHT)));
      take        = !eff_done && !empty_done && !pixel_skip;
      drain_now   = eff_drain || start_drain;
      col_next    = HWM_W'(eff_col) + HWM_W'(1);
      row_end     = (col_next >= width_use);

      // entries at or above the fill mark were not written in this frame
      cmd.frame_start = req_frame_start;
      cmd.col_zero    = (eff_col == '0);
      cmd.eval        = (eff_row != '0);
      cmd.bottom      = (req_operation == OP_PIXEL) && req_open_cell;
      cmd.center_ok   = (HWM_W'(eff_col) < eff_hwm);
      cmd.right_ok    = (col_next < width_use) && (col_next < eff_hwm);
      cmd.col         = eff_col;
      cmd.row         = ROW_W'(eff_row - RCNT_W'(1));

      done_in  = done_ff;
      drain_in = drain_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      hwm_in   = hwm_ff;
      if (accept) begin
         done_in  = eff_done;
         drain_in = eff_drain;
         col_in   = eff_col;
         row_in   = eff_row;
         hwm_in   = eff_hwm;
         if (!eff_done) begin
            if (start_drain) begin
               drain_in = 1'b1;
            end
            if (empty_done) begin
               done_in = 1'b1;
            end else if (take) begin
               if (col_next > eff_hwm) begin
                  hwm_in = col_next;
               end
               if (row_end) begin
                  col_in = '0;
                  if (drain_now) begin
                     done_in = 1'b1;
                  end else begin
                     row_in = eff_row + RCNT_W'(1);
                  end
               end else begin
                  col_in = COL_W'(col_next);
               end
            end
         end
      end
   end

   assign cmd_push = accept && take;
   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
         done_ff       <= 1'b0;
         drain_ff      <= 1'b0;
         col_ff        <= '0;
         row_ff        <= '0;
         hwm_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            grid_width_ff <= csr_write_data;
         end
         done_ff  <= done_in;
         drain_ff <= drain_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         hwm_ff   <= hwm_in;
      end
   end

endmodule

// ===== hdl/mjge_back.sv =====
// ----------------------------------------------------------------------------
// mjge_back
// Evaluates queued cells against the line and column stores and registers
// one result per junction node.
// ----------------------------------------------------------------------------
module mjge_back
   import mjge_pkg::*;
#(
   parameter  int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter  int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int COL_W      = $clog2(MAX_WIDTH),
   localparam int ROW_W      = $clog2(MAX_HEIGHT),
   localparam int CMD_W      = CMD_FLAG_COUNT + COL_W + ROW_W,
   localparam int WORD_W     = 3 + ROW_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  logic [CMD_W-1:0]   cmd_data,
   output logic               cmd_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [COORD_W-1:0] rsp_node_x,
   output logic [COORD_W-1:0] rsp_node_y,
   output logic               rsp_row_link_valid,
   output logic [COORD_W-1:0] rsp_row_link_length,
   output logic               rsp_col_link_valid,
   output logic [COORD_W-1:0] rsp_col_link_length,
   output logic               rsp_first_node
);

   typedef struct packed {
      logic             frame_start;
      logic             col_zero;
      logic             eval;
      logic             bottom;
      logic             center_ok;
      logic             right_ok;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cmd_type;

   typedef struct packed {
      logic             line_a;
      logic             line_b;
      logic             col_valid;
      logic [ROW_W-1:0] col_row;
   } word_type;

   logic             s1_valid_ff, s2_valid_ff;
   cmd_type          s1_cmd_ff, s2_cmd_ff;
   logic             hit_a_ff, hit_b_ff;
   word_type         byp_ff;
   logic             left_ff, row_valid_ff, node_seen_ff;
   logic [COL_W-1:0] row_col_ff;

   logic             rsp_valid_ff;
   coord_type        rsp_node_x_ff, rsp_node_y_ff, rsp_row_len_ff, rsp_col_len_ff;
   logic             rsp_row_valid_ff, rsp_col_valid_ff, rsp_first_ff;

   logic             advance, s1_load, s2_fire, rd_en;
   logic [COL_W-1:0] addr_b;
   word_type         ram_a_q, ram_b_q, word_a, word_b, word_wr;
   logic             center, top, right, left, bottom, is_node;
   logic             row_valid_eff, node_seen_eff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign s1_load = !s1_valid_ff || advance;
   assign cmd_pop = s1_load && cmd_valid;
   assign s2_fire = s2_valid_ff && advance;
   assign rd_en   = advance && s1_valid_ff;
   assign addr_b  = s1_cmd_ff.col + COL_W'(1);

   // two copies so the cell and its right neighbor are read together
   mjge_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_store_a (
      .clock   (clock),
      .wr_en   (s2_fire),
      .wr_addr (s2_cmd_ff.col),
      .wr_data (word_wr),
      .rd_en   (rd_en),
      .rd_addr (s1_cmd_ff.col),
      .rd_data (ram_a_q)
   );

   mjge_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_store_b (
      .clock   (clock),
      .wr_en   (s2_fire),
      .wr_addr (s2_cmd_ff.col),
      .wr_data (word_wr),
      .rd_en   (rd_en),
      .rd_addr (addr_b),
      .rd_data (ram_b_q)
   );

   always_comb begin
      word_a = s2_cmd_ff.center_ok ? (hit_a_ff ? byp_ff : ram_a_q) : '0;
      word_b = hit_b_ff ? byp_ff : ram_b_q;

      center        = word_a.line_b;
      top           = word_a.line_a;
      right         = s2_cmd_ff.right_ok && word_b.line_b;
      left          = !s2_cmd_ff.col_zero && left_ff;
      bottom        = s2_cmd_ff.bottom;
      row_valid_eff = !s2_cmd_ff.col_zero && row_valid_ff;
      node_seen_eff = !s2_cmd_ff.frame_start && node_seen_ff;

      is_node = s2_cmd_ff.eval && center &&
                ((left != right) || (top != bottom) || (top && bottom && left && right));

      // shift the column down one row and update its last node
      word_wr.line_a    = center;
      word_wr.line_b    = bottom;
      word_wr.col_valid = word_a.col_valid;
      word_wr.col_row   = word_a.col_row;
      if (s2_cmd_ff.eval && !center) begin
         word_wr.col_valid = 1'b0;
      end else if (is_node) begin
         word_wr.col_valid = 1'b1;
         word_wr.col_row   = s2_cmd_ff.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         hit_a_ff     <= 1'b0;
         hit_b_ff     <= 1'b0;
         left_ff      <= 1'b0;
         row_valid_ff <= 1'b0;
         node_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= cmd_valid;
         end
         if (advance) begin
            s2_valid_ff  <= s1_valid_ff;
            hit_a_ff     <= s2_fire && (s2_cmd_ff.col == s1_cmd_ff.col);
            hit_b_ff     <= s2_fire && (s2_cmd_ff.col == addr_b);
            rsp_valid_ff <= s2_fire && is_node;
         end
         if (s2_fire) begin
            left_ff      <= center;
            node_seen_ff <= node_seen_eff || is_node;
            if (s2_cmd_ff.eval && !center) begin
               row_valid_ff <= 1'b0;
            end else if (is_node) begin
               row_valid_ff <= 1'b1;
            end else begin
               row_valid_ff <= row_valid_eff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         s1_cmd_ff <= cmd_data;
      end
      if (advance) begin
         s2_cmd_ff <= s1_cmd_ff;
         byp_ff    <= word_wr;
      end
      if (s2_fire && is_node) begin
         row_col_ff       <= s2_cmd_ff.col;
         rsp_node_x_ff    <= coord_type'(s2_cmd_ff.col);
         rsp_node_y_ff    <= coord_type'(s2_cmd_ff.row);
         rsp_row_valid_ff <= row_valid_eff;
         rsp_row_len_ff   <= row_valid_eff ? coord_type'(s2_cmd_ff.col - row_col_ff) : '0;
         rsp_col_valid_ff <= word_a.col_valid;
         rsp_col_len_ff   <= word_a.col_valid ?
                             coord_type'(s2_cmd_ff.row - word_a.col_row) : '0;
         rsp_first_ff     <= !node_seen_eff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_node_x          = rsp_node_x_ff;
   assign rsp_node_y          = rsp_node_y_ff;
   assign rsp_row_link_valid  = rsp_row_valid_ff;
   assign rsp_row_link_length = rsp_row_len_ff;
   assign rsp_col_link_valid  = rsp_col_valid_ff;
   assign rsp_col_link_length = rsp_col_len_ff;
   assign rsp_first_node      = rsp_first_ff;

`ifndef SYNTHESIS
   first_node_unlinked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_first_ff |-> !rsp_row_valid_ff && !rsp_col_valid_ff)
      else $error("first node of a frame carries a link");

   row_length_unlinked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_row_valid_ff |-> rsp_row_len_ff == '0)
      else $error("row link length without a row link");

   col_length_unlinked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_col_valid_ff |-> rsp_col_len_ff == '0)
      else $error("column link length without a column link");

   stall_holds_eval: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !advance |=> s2_valid_ff && $stable(s2_cmd_ff))
      else $error("evaluation stage moved while the result was stalled");
`endif

endmodule

// ===== hdl/maze_junction_graph_extractor_core.sv =====
// ----------------------------------------------------------------------------
// maze_junction_graph_extractor_core
// Streams a binary maze in raster order, one cell per transaction, and emits
// one transaction per junction node with its coordinates and links to the
// nearest earlier node in its row and column. The block sustains one cell per
// clock: a cell is accepted every cycle while the result channel keeps up, and
// a result for a node is registered after the cell one row below it passes
// through the queue, the store read and the evaluation stage. The
// rate is set by the column store, whose read of a column and write-back of
// the same column run in consecutive pipeline stages with a bypass, so one
// column completes per cycle. Results hold in the output register while the
// consumer stalls; the command queue keeps accepting cells until it fills. A
// frame_start clears all stores at once through a fill mark, so there is no
// clearing pass after reset or between frames. After the last row, send one
// flush step per column to evaluate it; a flush in the middle of a row pads it
// with a wall.
// ----------------------------------------------------------------------------
module maze_junction_graph_extractor_core
   import mjge_pkg::*;
#(
   parameter  int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter  int MAX_HEIGHT = DEFAULT_MAX_HEIGHT,
   localparam int COL_W      = $clog2(MAX_WIDTH),
   localparam int ROW_W      = $clog2(MAX_HEIGHT),
   localparam int CMD_W      = CMD_FLAG_COUNT + COL_W + ROW_W
) (
   input  logic                    clock,
   input  logic                    reset,

   // grid width register, columns per row
   input  logic                    csr_write_enable,
   input  logic [GRID_WIDTH_W-1:0] csr_write_data,

   // cell transactions
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   input  logic                    req_open_cell,
   input  logic                    req_frame_start,

   // node transactions
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [COORD_W-1:0]      rsp_node_x,
   output logic [COORD_W-1:0]      rsp_node_y,
   output logic                    rsp_row_link_valid,
   output logic [COORD_W-1:0]      rsp_row_link_length,
   output logic                    rsp_col_link_valid,
   output logic [COORD_W-1:0]      rsp_col_link_length,
   output logic                    rsp_first_node
);

   // command path from classifier to evaluator
   logic             cmd_push, cmd_pop, cmd_valid, queue_full;
   logic [CMD_W-1:0] cmd_push_data, cmd_pop_data;

   // Front end: track column, row, drain and done state, drop ignored
   // cells, and tag each evaluated cell with which stored entries belong
   // to the current frame.
   mjge_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_open_cell    (req_open_cell),
      .req_frame_start  (req_frame_start),
      .queue_full       (queue_full),
      .cmd_push         (cmd_push),
      .cmd_data         (cmd_push_data)
   );

   // Hold commands so a stalled result does not stop cell intake at once.
   mjge_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_data  (cmd_pop_data),
      .full      (queue_full)
   );

   // Back end: read the column, evaluate the cell one row behind, write the
   // column back and register the node result.
   mjge_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_valid           (cmd_valid),
      .cmd_data            (cmd_pop_data),
      .cmd_pop             (cmd_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_node_x          (rsp_node_x),
      .rsp_node_y          (rsp_node_y),
      .rsp_row_link_valid  (rsp_row_link_valid),
      .rsp_row_link_length (rsp_row_link_length),
      .rsp_col_link_valid  (rsp_col_link_valid),
      .rsp_col_link_length (rsp_col_link_length),
      .rsp_first_node      (rsp_first_node)
   );

endmodule

// ===== tb/sv/junction_node_checker.sv =====
// ----------------------------------------------------------------------------
// junction_node_checker
// Watches the cell, node and grid width ports of the junction extractor,
// predicts the node transactions from the accepted cells and compares every
// accepted node, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module junction_node_checker
   import mjge_pkg::*;
#(
   parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [GRID_WIDTH_W-1:0] csr_write_data,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_operation,
   input  logic                    req_open_cell,
   input  logic                    req_frame_start,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [COORD_W-1:0]      rsp_node_x,
   input  logic [COORD_W-1:0]      rsp_node_y,
   input  logic                    rsp_row_link_valid,
   input  logic [COORD_W-1:0]      rsp_row_link_length,
   input  logic                    rsp_col_link_valid,
   input  logic [COORD_W-1:0]      rsp_col_link_length,
   input  logic                    rsp_first_node,
   output int                      node_backlog,
   output int                      node_errors
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      row_linked;
      coord_type row_length;
      logic      col_linked;
      coord_type col_length;
      logic      first;
   } junction_node_type;

   junction_node_type expected_nodes[$];

   // predictor state
   bit                    row_above[MAX_WIDTH];
   bit                    row_eval[MAX_WIDTH];
   bit                    col_node_linked[MAX_WIDTH];
   int                    col_node_row[MAX_WIDTH];
   bit                    row_node_linked;
   int                    row_node_col;
   int                    col_count;
   int                    row_count;
   bit                    any_node_seen;
   bit                    left_cell;
   bit                    draining;
   bit                    frame_done;
   logic [GRID_WIDTH_W-1:0] grid_width;
   int                    error_total;

   function automatic void clear_frame();
      for (int k = 0; k < MAX_WIDTH; k++) begin
         row_above[k]       = 1'b0;
         row_eval[k]        = 1'b0;
         col_node_linked[k] = 1'b0;
         col_node_row[k]    = 0;
      end
      row_node_linked = 1'b0;
      row_node_col    = 0;
      col_count       = 0;
      row_count       = 0;
      any_node_seen   = 1'b0;
      left_cell       = 1'b0;
      draining        = 1'b0;
      frame_done      = 1'b0;
   endfunction

   // Advance the grid by one cell; return 1 when the cell one row up is a node.
   function automatic bit evaluate_cell(input op_type op, input logic cell_in,
                                        input logic fs, output junction_node_type node);
      int width_used;
      int j;
      int i;
      bit below;
      bit above;
      bit here;
      bit right_cell;
      bit left_now;
      bit found;
      found = 1'b0;
      node  = '0;
      if (fs) clear_frame();
      if (frame_done) return 1'b0;
      if (op == OP_FLUSH) begin
         if (!draining && !(col_count != 0 && row_count < MAX_HEIGHT)) begin
            draining = 1'b1;
            if (row_count == 0) begin
               frame_done = 1'b1;
               return 1'b0;
            end
         end
         below = 1'b0;
      end else begin
         if (draining || row_count >= MAX_HEIGHT) return 1'b0;
         below = cell_in;
      end
      width_used = int'(grid_width);
      if (width_used < 1) width_used = 1;
      if (width_used > MAX_WIDTH) width_used = MAX_WIDTH;
      j = col_count;
      if (j >= MAX_WIDTH) j = MAX_WIDTH - 1;
      if (j == 0) begin
         left_cell       = 1'b0;
         row_node_linked = 1'b0;
      end
      left_now   = left_cell;
      here       = row_eval[j];
      above      = row_above[j];
      right_cell = (j + 1 < width_used && j + 1 < MAX_WIDTH) ? row_eval[j + 1] : 1'b0;
      if (row_count >= 1) begin
         i = row_count - 1;
         if (!here) begin
            row_node_linked    = 1'b0;
            col_node_linked[j] = 1'b0;
         end else if (left_now != right_cell || above != below ||
                      (above && below && left_now && right_cell)) begin
            node.x          = coord_type'(j);
            node.y          = coord_type'(i);
            node.row_linked = row_node_linked;
            node.row_length = row_node_linked ? coord_type'(j - row_node_col) : '0;
            node.col_linked = col_node_linked[j];
            node.col_length = col_node_linked[j] ? coord_type'(i - col_node_row[j]) : '0;
            node.first      = !any_node_seen;
            any_node_seen      = 1'b1;
            row_node_linked    = 1'b1;
            row_node_col       = j;
            col_node_linked[j] = 1'b1;
            col_node_row[j]    = i;
            found = 1'b1;
         end
      end
      left_cell    = here;
      row_above[j] = here;
      row_eval[j]  = below;
      j++;
      if (j >= width_used) begin
         col_count = 0;
         if (draining) frame_done = 1'b1;
         else row_count++;
      end else begin
         col_count = j;
      end
      return found;
   endfunction

   always @(posedge clock) begin
      junction_node_type predicted;
      junction_node_type observed;
      if (reset) begin
         clear_frame();
         grid_width = GRID_WIDTH_RESET;
         expected_nodes.delete();
         error_total = 0;
         node_backlog <= 0;
         node_errors  <= 0;
      end else begin
         if (csr_write_enable) grid_width = csr_write_data;
         if (req_valid && req_ready) begin
            if (evaluate_cell(op_type'(req_operation), req_open_cell, req_frame_start,
                              predicted))
               expected_nodes.insert(expected_nodes.size(), predicted);
         end
         if (rsp_valid && rsp_ready) begin
            observed = '{rsp_node_x, rsp_node_y, rsp_row_link_valid, rsp_row_link_length,
                         rsp_col_link_valid, rsp_col_link_length, rsp_first_node};
            if (expected_nodes.size() == 0) begin
               error_total++;
               if (error_total <= 10)
                  $display("%0t: node (%0d,%0d) arrived with none expected",
                           $realtime, observed.x, observed.y);
            end else begin
               predicted = expected_nodes.pop_front();
               if (observed.x !== predicted.x || observed.y !== predicted.y ||
                   observed.row_linked !== predicted.row_linked ||
                   observed.row_length !== predicted.row_length ||
                   observed.col_linked !== predicted.col_linked ||
                   observed.col_length !== predicted.col_length ||
                   observed.first !== predicted.first) begin
                  error_total++;
                  if (error_total <= 10) begin
                     $display("%0t: node mismatch, x y rowlink rowlen collink collen first",
                              $realtime);
                     $display("   expected %0d %0d %0d %0d %0d %0d %0d",
                              predicted.x, predicted.y, predicted.row_linked,
                              predicted.row_length, predicted.col_linked,
                              predicted.col_length, predicted.first);
                     $display("   actual   %0d %0d %0d %0d %0d %0d %0d",
                              observed.x, observed.y, observed.row_linked,
                              observed.row_length, observed.col_linked,
                              observed.col_length, observed.first);
                  end
               end
            end
         end
         node_backlog <= expected_nodes.size();
         node_errors  <= error_total;
      end
   end

endmodule

// ===== tb/sv/tb_maze_junction_graph_extractor_core.sv =====
// ----------------------------------------------------------------------------
// tb_maze_junction_graph_extractor_core
// Drives maze frames of many grid widths into the junction extractor, from
// short hand-built frames to one full-height frame, with random sender bursts
// and receiver stalls; the node checker beside the block predicts and
// compares every node transaction.
// ----------------------------------------------------------------------------
module tb_maze_junction_graph_extractor_core
   import mjge_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Quiet cycles allowed: the long receiver hold, a sender gap and the
   // settle pause all fit many times over.
   localparam int WATCHDOG_LIMIT = 5000;
   // Cycles to let the pipeline empty after the last expected node.
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int SMALL_PHASES   = 4;
   localparam int PHASE_ITEMS    = 110;

   typedef enum int {
      FRAME_CLEAN,      // whole rows, then one flush per column
      FRAME_PADDED,     // last row cut short, flushes pad it and then drain
      FRAME_ABANDONED   // left open, the next frame_start drops it
   } frame_shape_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_write_enable;
   logic [GRID_WIDTH_W-1:0] csr_write_data;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_operation;
   logic                    req_open_cell;
   logic                    req_frame_start;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [COORD_W-1:0]      rsp_node_x;
   logic [COORD_W-1:0]      rsp_node_y;
   logic                    rsp_row_link_valid;
   logic [COORD_W-1:0]      rsp_row_link_length;
   logic                    rsp_col_link_valid;
   logic [COORD_W-1:0]      rsp_col_link_length;
   logic                    rsp_first_node;

   int node_backlog;
   int node_errors;
   int quiet_cycles = 0;
   int burst_left   = 0;
   int items_sent   = 0;

   always #5 clock = ~clock;

   maze_junction_graph_extractor_core DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_open_cell       (req_open_cell),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_node_x          (rsp_node_x),
      .rsp_node_y          (rsp_node_y),
      .rsp_row_link_valid  (rsp_row_link_valid),
      .rsp_row_link_length (rsp_row_link_length),
      .rsp_col_link_valid  (rsp_col_link_valid),
      .rsp_col_link_length (rsp_col_link_length),
      .rsp_first_node      (rsp_first_node)
   );

   junction_node_checker u_node_checker (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_open_cell       (req_open_cell),
      .req_frame_start     (req_frame_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_node_x          (rsp_node_x),
      .rsp_node_y          (rsp_node_y),
      .rsp_row_link_valid  (rsp_row_link_valid),
      .rsp_row_link_length (rsp_row_link_length),
      .rsp_col_link_valid  (rsp_col_link_valid),
      .rsp_col_link_length (rsp_col_link_length),
      .rsp_first_node      (rsp_first_node),
      .node_backlog        (node_backlog),
      .node_errors         (node_errors)
   );

   // open_weight out of 256; 256 gives an all-open stretch
   function automatic logic random_cell(input int open_weight);
      return $urandom_range(255) < open_weight;
   endfunction

   // Offer one cell transaction and hold it until the block takes it. Gaps
   // fall only between bursts, so valid never drops under a pending offer.
   task automatic send_item(input op_type op, input logic open_in, input logic fs);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 40);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_open_cell   <= open_in;
      req_frame_start <= fs;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // Drop valid, wait for every predicted node, then let the pipeline settle.
   // The backlog is registered, so it is read only from the next edge on.
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (node_backlog != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_grid_width(input logic [GRID_WIDTH_W-1:0] value);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One frame: frame_start on its first transaction, rows of random cells,
   // then, unless abandoned, the flushes that pad a cut row and drain the last.
   task automatic send_frame(input int w, input int rows, input int open_weight,
                             input frame_shape_type shape);
      int k;
      int tail;
      int flushes;
      for (k = 0; k < rows * w; k++)
         send_item(OP_PIXEL, random_cell(open_weight), k == 0);
      if (shape == FRAME_CLEAN) tail = 0;
      else if (shape == FRAME_PADDED) tail = (w > 1) ? $urandom_range(1, w - 1) : 0;
      else tail = $urandom_range(0, w - 1);
      for (k = 0; k < tail; k++)
         send_item(OP_PIXEL, random_cell(open_weight), rows == 0 && k == 0);
      if (shape != FRAME_ABANDONED) begin
         // no rows at all: a single flush ends the frame on the spot
         flushes = (rows == 0 && tail == 0) ? 1 : (tail == 0 ? w : 2 * w - tail);
         for (k = 0; k < flushes; k++)
            send_item(OP_FLUSH, 1'($urandom_range(1)), rows == 0 && tail == 0 && k == 0);
      end
   endtask

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: stall in segments of random mode, with up to two long holds
   // taken while the sender is offering, so the block backs up into its input.
   initial begin : node_sink
      int seg_left;
      int mode;
      int cycle_no;
      int holds_done;
      seg_left   = 0;
      mode       = 0;
      cycle_no   = 0;
      holds_done = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (!reset && holds_done < 2 && cycle_no >= 1500 + holds_done * 500 &&
             rsp_valid && req_valid) begin
            holds_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               mode     = $urandom_range(3);
               seg_left = $urandom_range(10, 200);
            end
            seg_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(1));
               2: rsp_ready <= ($urandom_range(3) == 0);
               default: rsp_ready <= (cycle_no % 3 != 0);
            endcase
         end
      end
   end

   initial begin : cell_source
      int              phase;
      int              w;
      int              k;
      int              phase_start;
      int              pick;
      int              open_weight;
      bit              frame_open;
      frame_shape_type shape;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = OP_PIXEL;
      req_open_cell    = 1'b0;
      req_frame_start  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Hand-built 3-wide frame. Row 1 center has all four neighbors open;
      // row 2 is cut short by a flush that stands for a wall.
      write_grid_width(GRID_WIDTH_W'(3));
      send_item(OP_PIXEL, 1'b1, 1'b1);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_PIXEL, 1'b0, 1'b0);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_FLUSH, 1'b1, 1'b0);
      // drain the last row; a cell offered mid-drain must be dropped
      send_item(OP_FLUSH, 1'b0, 1'b0);
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_FLUSH, 1'b1, 1'b0);
      send_item(OP_FLUSH, 1'b0, 1'b0);
      // frame is done: both a cell and a flush are dropped
      send_item(OP_PIXEL, 1'b1, 1'b0);
      send_item(OP_FLUSH, 1'b1, 1'b0);
      // flush with no rows ends a fresh frame at once
      send_item(OP_FLUSH, 1'b0, 1'b1);
      send_item(OP_PIXEL, 1'b1, 1'b0);

      // Width 0 clamps to one column: run past the row limit so the extra
      // cells are dropped, then drain row 1023.
      write_grid_width('0);
      send_frame(1, 1030, 255, FRAME_CLEAN);

      // Small widths: mostly well-formed frames, some noise. Every other
      // phase leaves a frame open across the width change.
      frame_open = 1'b0;
      for (phase = 0; phase < SMALL_PHASES; phase++) begin
         w = (phase == 0) ? 2 : $urandom_range(1, 16);
         write_grid_width(GRID_WIDTH_W'(w));
         if (frame_open) begin
            // carry on the old frame under the new width, then drain it
            for (k = $urandom_range(1, 3 * w); k > 0; k--)
               send_item(OP_PIXEL, random_cell(192), 1'b0);
            for (k = 0; k < 2 * w; k++)
               send_item(OP_FLUSH, 1'($urandom_range(1)), 1'b0);
            frame_open = 1'b0;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(7) == 0) begin
               for (k = $urandom_range(1, 3); k > 0; k--)
                  send_item(op_type'($urandom_range(1)), 1'($urandom_range(1)),
                            $urandom_range(15) == 0);
            end
            case ($urandom_range(3))
               0: open_weight = 128;
               1: open_weight = 176;
               2: open_weight = 224;
               default: open_weight = 256;
            endcase
            pick = $urandom_range(9);
            if (pick < 7) shape = FRAME_CLEAN;
            else if (pick < 9) shape = FRAME_PADDED;
            else shape = FRAME_ABANDONED;
            send_frame(w, $urandom_range(0, 6), open_weight, shape);
         end
         if (phase % 2 == 0) begin
            send_frame(w, $urandom_range(1, 3), 192, FRAME_ABANDONED);
            frame_open = 1'b1;
         end
      end

      // All-ones width clamps to the maximum; stray traffic, no nodes.
      write_grid_width('1);
      for (k = 0; k < 24; k++)
         send_item(op_type'($urandom_range(1)), 1'($urandom_range(1)), k == 0);

      wait_until_idle();
      if (node_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mjge_pkg.sv
hdl/mjge_ram.sv
hdl/mjge_queue.sv
hdl/mjge_front.sv
hdl/mjge_back.sv
hdl/maze_junction_graph_extractor_core.sv
tb/sv/junction_node_checker.sv
tb/sv/tb_maze_junction_graph_extractor_core.sv
